// ===== rtl/mwsm_pkg.sv =====
// Package for the multi-pattern wildcard stream matcher.
// Holds byte codes, register indexes and small helpers; no dependencies.
package mwsm_pkg;

  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned PCOUNT_W    = 3;
  localparam int unsigned PREG_COUNT  = 4;

  localparam logic [7:0] STAR_BYTE    = 8'h2A;
  localparam logic [7:0] ANY_BYTE     = 8'h3F;
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0] LOWER_A      = 8'h61;
  localparam logic [7:0] LOWER_Z      = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  localparam logic [COUNT_W-1:0] COUNT_ONE = 16'd1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_ZERO  = 3'd0,
    REG_PATTERN_ONE   = 3'd1,
    REG_PATTERN_TWO   = 3'd2,
    REG_PATTERN_THREE = 3'd3,
    REG_PATTERN_COUNT = 3'd4,
    REG_FOLD_CASE     = 3'd5
  } cfg_reg_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold);
    logic [7:0] r;
    r = b;
    if (fold && b >= LOWER_A && b <= LOWER_Z) r = b - CASE_OFFSET;
    return r;
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] r;
    r = v;
    if (v != COUNT_MAX) r = v + COUNT_ONE;
    return r;
  endfunction

endpackage

// ===== rtl/multi_wildcard_stream_matcher.sv =====
// Top level of the multi-pattern wildcard stream matcher.
// Depends on mwsm_pkg for byte codes, register indexes and helpers.
//
// Usage: text words enter on the s_ channel, one byte per word, with the
// file-start flag in s_tuser. Each word is first held in an input register;
// when the result register is free, all pattern matchers step in parallel in
// one pass and the set of completed patterns lands in it. The result register
// then sends one word per completed pattern on the m_ channel, lowest
// pattern index first, with m_tlast on the final one for that byte. A byte
// that completes nothing produces no output word.
// Throughput is one byte per cycle while the result register is free; a byte
// that completes k patterns holds the result register until its k words have
// drained, and input acceptance waits meanwhile. When the receiver stalls, the
// result register and then the input register fill and s_tready falls.
// Configuration writes (patterns, pattern count, case folding) take effect
// at once; the user must make them while the stream is idle; the block does not
// enforce it. Synchronous reset clears patterns and count, sets case folding,
// sets line and column to 1, empties both registers; no clearing pass is needed.
module multi_wildcard_stream_matcher
  import mwsm_pkg::*;
#(
  parameter int unsigned PATTERNS      = 4,
  parameter int unsigned PATTERN_BYTES = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input stream.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // [7:0] text_byte
  input  logic [0:0]             s_tuser,   // [0] file_start
  // Result stream.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [39:0]            m_tdata,   // [1:0] pattern_index, [17:2] match_line,
                                            // [33:18] match_column, [39:34] zero
  output logic                   m_tlast,   // last_of_run
  // Configuration write port.
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned SEL_W = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
  localparam int unsigned EFF_DEPTH = 32;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] pat_reg [PREG_COUNT];
  logic [PCOUNT_W-1:0]   pattern_count;
  logic                  fold_case;

  // Input register.
  logic                  in_valid;
  logic [7:0]            in_byte;
  logic                  in_fs;

  // Scan state.
  logic [COUNT_W-1:0]    line_cnt;
  logic [COUNT_W-1:0]    col_cnt;
  logic [POS_W-1:0]      mpos  [PATTERNS];
  logic [COUNT_W-1:0]    sline [PATTERNS];
  logic [COUNT_W-1:0]    scol  [PATTERNS];

  logic [POS_W-1:0]      mpos_next  [PATTERNS];
  logic [COUNT_W-1:0]    sline_next [PATTERNS];
  logic [COUNT_W-1:0]    scol_next  [PATTERNS];
  logic [PATTERNS-1:0]   hit;
  logic [COUNT_W-1:0]    hit_line_next [PATTERNS];
  logic [COUNT_W-1:0]    hit_col_next  [PATTERNS];

  // Result register.
  logic [PATTERNS-1:0]   pend;
  logic [COUNT_W-1:0]    hit_line [PATTERNS];
  logic [COUNT_W-1:0]    hit_col  [PATTERNS];

  logic                  advance;
  logic                  res_free;
  logic                  take;
  logic [PATTERNS-1:0]   sel_onehot;
  logic [SEL_W-1:0]      sel;
  logic [PATTERNS-1:0]   rest;

  logic [7:0]            c;
  logic                  is_nl;
  logic [COUNT_W-1:0]    line_b;
  logic [COUNT_W-1:0]    col_b;
  logic [COUNT_W-1:0]    line_next;
  logic [COUNT_W-1:0]    col_next;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PREG_COUNT; i++) pat_reg[i] <= '0;
      pattern_count <= '0;
      fold_case     <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_ZERO:  pat_reg[0] <= cfg_data;
        REG_PATTERN_ONE:   pat_reg[1] <= cfg_data;
        REG_PATTERN_TWO:   pat_reg[2] <= cfg_data;
        REG_PATTERN_THREE: pat_reg[3] <= cfg_data;
        REG_PATTERN_COUNT: pattern_count <= cfg_data[PCOUNT_W-1:0];
        REG_FOLD_CASE:     fold_case <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Handshake. The input register moves on when the result register is
  // empty or is sending its last word in this cycle.
  assign m_tvalid = |pend;
  assign take     = m_tvalid && m_tready;
  assign res_free = !m_tvalid || (take && (rest == '0));
  assign advance  = in_valid && res_free;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_fs   <= s_tuser[0];
    end
  end

  // Shared line and column logic. File start acts before the byte.
  always_comb begin
    c         = fold_byte(in_byte, fold_case);
    is_nl     = (c == NEWLINE_BYTE);
    line_b    = in_fs ? COUNT_ONE : line_cnt;
    col_b     = in_fs ? COUNT_ONE : col_cnt;
    line_next = is_nl ? sat_inc(line_b) : line_b;
    col_next  = is_nl ? COUNT_ONE : sat_inc(col_b);
  end

  // One matcher per pattern, all stepping on the same byte.
  for (genvar p = 0; p < PATTERNS; p++) begin : g_match
    logic [CFG_DATA_W-1:0] pat_w;
    logic                  en;
    logic [7:0]            eff [EFF_DEPTH];
    logic [4:0]            pe;
    logic [4:0]            np;
    logic [7:0]            v;
    logic [7:0]            nx;
    logic [7:0]            nv;
    logic [7:0]            nv2;
    logic                  adv;
    logic                  hold;
    logic                  done;
    logic [POS_W-1:0]      pos_b;
    logic [COUNT_W-1:0]    sl_b;
    logic [COUNT_W-1:0]    sc_b;
    logic [POS_W-1:0]      pos_o;
    logic [COUNT_W-1:0]    sl_o;
    logic [COUNT_W-1:0]    sc_o;

    if (p < PREG_COUNT) begin : g_reg
      assign pat_w = pat_reg[p];
    end else begin : g_noreg
      assign pat_w = '0;
    end

    assign en = ({2'b00, pattern_count} > 5'(p));

    // Effective pattern bytes: zero from the first zero byte onward.
    always_comb begin
      logic alive;
      alive = 1'b1;
      for (int k = 0; k < EFF_DEPTH; k++) eff[k] = 8'h00;
      for (int k = 0; k < PATTERN_BYTES; k++) begin
        alive  = alive && (pat_w[8*k +: 8] != 8'h00);
        eff[k] = alive ? pat_w[8*k +: 8] : 8'h00;
      end
    end

    always_comb begin
      pos_b = in_fs ? '0 : mpos[p];
      sl_b  = in_fs ? COUNT_ONE : sline[p];
      sc_b  = in_fs ? COUNT_ONE : scol[p];
      pe    = {1'b0, pos_b};
      v     = eff[pe];
      nx    = eff[pe + 5'd1];
      adv   = 1'b0;
      hold  = 1'b0;
      np    = pe;
      if (v == STAR_BYTE) begin
        // A star waits for the byte after it; no restart while waiting.
        if (nx == 8'h00 || nx != c) begin
          hold = 1'b1;
        end else begin
          adv = 1'b1;
          np  = pe + 5'd2;
        end
      end else if (v == ANY_BYTE || (v != 8'h00 && v == c)) begin
        adv = 1'b1;
        np  = pe + 5'd1;
      end
      nv   = eff[np];
      nv2  = eff[np + 5'd1];
      done = adv && (nv == 8'h00 || (nv == STAR_BYTE && nv2 == 8'h00));

      pos_o = pos_b;
      sl_o  = sl_b;
      sc_o  = sc_b;
      if (is_nl) begin
        pos_o = '0;
        sl_o  = line_next;
        sc_o  = col_next;
      end else if (en) begin
        if (adv && !done) begin
          pos_o = np[POS_W-1:0];
        end else if (!hold) begin
          // Mismatch or completion restarts the match at the next byte's column.
          pos_o = '0;
          sl_o  = line_next;
          sc_o  = col_next;
        end
      end
    end

    assign hit[p]           = !is_nl && en && done;
    assign hit_line_next[p] = sl_b;
    assign hit_col_next[p]  = sc_b - COUNT_ONE;
    assign mpos_next[p]     = pos_o;
    assign sline_next[p]    = sl_o;
    assign scol_next[p]     = sc_o;
  end

  // Scan state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_cnt <= COUNT_ONE;
      col_cnt  <= COUNT_ONE;
      for (int i = 0; i < PATTERNS; i++) begin
        mpos[i]  <= '0;
        sline[i] <= COUNT_ONE;
        scol[i]  <= COUNT_ONE;
      end
    end else if (advance) begin
      line_cnt <= line_next;
      col_cnt  <= col_next;
      for (int i = 0; i < PATTERNS; i++) begin
        mpos[i]  <= mpos_next[i];
        sline[i] <= sline_next[i];
        scol[i]  <= scol_next[i];
      end
    end
  end

  // Result register: pending completions and their start positions.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (advance) begin
      pend <= hit;
    end else if (take) begin
      pend <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < PATTERNS; i++) begin
        hit_line[i] <= hit_line_next[i];
        hit_col[i]  <= hit_col_next[i];
      end
    end
  end

  // Lowest pending pattern goes out first.
  always_comb begin
    sel_onehot = '0;
    sel        = '0;
    for (int i = PATTERNS - 1; i >= 0; i--) begin
      if (pend[i]) begin
        sel_onehot    = '0;
        sel_onehot[i] = 1'b1;
        sel           = SEL_W'(i);
      end
    end
    rest = pend & ~sel_onehot;
  end

  assign m_tdata = {6'b0, hit_col[sel], hit_line[sel], 2'(sel)};
  assign m_tlast = (rest == '0);

endmodule

// ===== verif/mwsm_checker.sv =====
// Checker for the multi-pattern wildcard stream matcher: watches the text,
// result and configuration ports, predicts each match word and compares.
// Depends on mwsm_pkg for byte codes, register indexes and widths.
`timescale 1ns / 100ps

module mwsm_checker
  import mwsm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [7:0]             s_tdata,
  input  logic [0:0]             s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [39:0]            m_tdata,
  input  logic                   m_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     errors,
  output int                     outstanding,
  output int                     matches_seen
);

  localparam int PAT_BYTES = 8;

  typedef struct packed {
    logic [1:0]         pat_idx;
    logic [COUNT_W-1:0] line_no;
    logic [COUNT_W-1:0] column_no;
    logic               closes_run;
  } match_rec_t;

  logic [63:0]         pat_reg [PREG_COUNT];
  logic [PCOUNT_W-1:0] pat_count;
  logic                fold;
  logic [POS_W-1:0]    mpos [PREG_COUNT];
  logic [COUNT_W-1:0]  scol [PREG_COUNT];
  logic [COUNT_W-1:0]  sline [PREG_COUNT];
  logic [COUNT_W-1:0]  line_cnt;
  logic [COUNT_W-1:0]  col_cnt;
  match_rec_t          hits_due [$];

  // Effective pattern byte: zero at and after the first zero byte.
  function automatic logic [7:0] pat_at(int p, int k);
    logic [7:0] b;
    int i;
    b = 8'h00;
    if (k >= PAT_BYTES) return 8'h00;
    for (i = 0; i <= k; i++) begin
      b = pat_reg[p][8*i +: 8];
      if (b == 8'h00) return 8'h00;
    end
    return b;
  endfunction

  function automatic void rearm(int p);
    mpos[p] = '0;
    scol[p] = col_cnt;
    sline[p] = line_cnt;
  endfunction

  always @(posedge clk) begin : watch
    logic [7:0] c;
    logic [7:0] v;
    logic [7:0] nx;
    logic       moved;
    int         p;
    int         pos;
    int         lim;
    int         n;
    match_rec_t want;
    if (rst) begin
      for (p = 0; p < PREG_COUNT; p++) pat_reg[p] = '0;
      pat_count = '0;
      fold = 1'b1;
      line_cnt = COUNT_ONE;
      col_cnt = COUNT_ONE;
      for (p = 0; p < PREG_COUNT; p++) rearm(p);
      hits_due.delete();
      errors = 0;
      matches_seen = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PATTERN_ZERO, REG_PATTERN_ONE, REG_PATTERN_TWO, REG_PATTERN_THREE: begin
            pat_reg[cfg_index[1:0]] = cfg_data;
          end
          REG_PATTERN_COUNT: pat_count = cfg_data[PCOUNT_W-1:0];
          REG_FOLD_CASE:     fold = cfg_data[0];
          default: ;
        endcase
      end

      if (s_tvalid && s_tready) begin
        if (s_tuser[0]) begin
          line_cnt = COUNT_ONE;
          col_cnt = COUNT_ONE;
          for (p = 0; p < PREG_COUNT; p++) rearm(p);
        end
        c = s_tdata;
        if (fold && c >= LOWER_A && c <= LOWER_Z) c = c - CASE_OFFSET;
        if (c == NEWLINE_BYTE) begin
          if (line_cnt != COUNT_MAX) line_cnt = line_cnt + COUNT_ONE;
          col_cnt = COUNT_ONE;
          for (p = 0; p < PREG_COUNT; p++) rearm(p);
        end else begin
          if (col_cnt != COUNT_MAX) col_cnt = col_cnt + COUNT_ONE;
          lim = (pat_count > PREG_COUNT) ? PREG_COUNT : pat_count;
          n = 0;
          for (p = 0; p < lim; p++) begin
            pos = mpos[p];
            v = pat_at(p, pos);
            moved = 1'b1;
            // A star holds its place until the byte after it shows up.
            if (v == STAR_BYTE) begin
              nx = pat_at(p, pos + 1);
              if (nx != 8'h00 && nx == c) pos = pos + 2;
              else moved = 1'b0;
            end else if (v == ANY_BYTE) begin
              pos = pos + 1;
            end else if (v != 8'h00 && v == c) begin
              pos = pos + 1;
            end else begin
              rearm(p);
              moved = 1'b0;
            end
            if (moved) begin
              mpos[p] = pos[POS_W-1:0];
              v = pat_at(p, pos);
              if (v == 8'h00 || (v == STAR_BYTE && pat_at(p, pos + 1) == 8'h00)) begin
                hits_due.push_back('{pat_idx: p[1:0], line_no: sline[p],
                                     column_no: scol[p] - COUNT_ONE, closes_run: 1'b0});
                n++;
                rearm(p);
              end
            end
          end
          if (n > 0) hits_due[hits_due.size() - 1].closes_run = 1'b1;
        end
      end

      if (m_tvalid && m_tready) begin
        if (hits_due.size() == 0) begin
          $error("result word %h with no match pending", m_tdata);
          errors++;
        end else begin
          want = hits_due.pop_front();
          matches_seen++;
          if (m_tdata[1:0] != want.pat_idx) begin
            $error("pattern_index: expected %0d, got %0d", want.pat_idx, m_tdata[1:0]);
            errors++;
          end
          if (m_tdata[17:2] != want.line_no) begin
            $error("match_line: expected %0d, got %0d", want.line_no, m_tdata[17:2]);
            errors++;
          end
          if (m_tdata[33:18] != want.column_no) begin
            $error("match_column: expected %0d, got %0d", want.column_no, m_tdata[33:18]);
            errors++;
          end
          if (m_tlast != want.closes_run) begin
            $error("last_of_run: expected %0d, got %0d", want.closes_run, m_tlast);
            errors++;
          end
          if (m_tdata[39:34] != '0) begin
            $error("tdata padding: expected 0, got %0h", m_tdata[39:34]);
            errors++;
          end
        end
      end
      outstanding <= hits_due.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the multi-pattern wildcard stream matcher: clock, reset,
// text and configuration stimulus, receiver stalls and the verdict.
// Depends on mwsm_pkg, the matcher RTL and mwsm_checker.
`timescale 1ns / 100ps

module tb;
  import mwsm_pkg::*;

  // Indexes past the register list; writes there must be ignored.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int RANDOM_SETTINGS = 6;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [7:0]             s_tdata;
  logic [0:0]             s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [39:0]            m_tdata;
  logic                   m_tlast;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     errors;
  int                     outstanding;
  int                     matches_seen;

  logic [63:0] pat_words [PREG_COUNT];
  int          phase_no;
  int          squeezed_phase;
  int          burst_left;
  bit          pacing;
  int          bytes_sent;

  multi_wildcard_stream_matcher dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mwsm_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding), .matches_seen(matches_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("** multi_wildcard_stream_matcher: FAILED **");
    $finish;
  end

  function automatic logic [7:0] filler_byte();
    case ($urandom_range(0, 3))
      0: return "A";
      1: return "B";
      2: return "C";
      default: return "X";
    endcase
  endfunction

  function automatic logic [63:0] pack_text(string s);
    logic [63:0] r;
    int i;
    r = '0;
    for (i = 0; i < s.len() && i < 8; i++) r[8*i +: 8] = s[i];
    return r;
  endfunction

  // Called at a falling edge; returns at a falling edge.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx < PREG_COUNT) pat_words[idx[1:0]] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Offers one text word and waits for it to be taken. When a burst ends,
  // tvalid stays low for a random gap, which may also be empty.
  task automatic offer_byte(input logic [7:0] b, input logic fs);
    int gap;
    s_tdata <= b;
    s_tuser <= fs;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = pacing ? $urandom_range(0, 6) : 0;
      burst_left = $urandom_range(1, 30);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic send_text(input string s, input bit fs_first);
    int i;
    for (i = 0; i < s.len(); i++) offer_byte(s[i], fs_first && i == 0);
  endtask

  // Lets every predicted match drain, then waits longer for bytes that match
  // nothing and are still in the pipeline.
  task automatic settle();
    int w;
    s_tvalid <= 1'b0;
    for (w = 0; w < 4000 && outstanding != 0; w++) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Receiver: stretches of different stall patterns, plus one long hold-off
  // per random setting while text keeps coming.
  initial begin
    int mode;
    int span;
    int i;
    m_tready = 1'b0;
    squeezed_phase = 0;
    @(negedge clk);
    forever begin
      if (phase_no > 0 && phase_no != squeezed_phase) begin
        squeezed_phase = phase_no;
        m_tready <= 1'b0;
        repeat (150) @(negedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(10, 60);
        for (i = 0; i < span; i++) begin
          case (mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 1);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= i[0];
          endcase
          @(negedge clk);
        end
      end
    end
  end

  initial begin
    int ph;
    int k;
    int i;
    int n;
    int r;
    int start;
    logic [7:0] b;
    logic [63:0] w;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    phase_no = 0;
    pacing = 1'b1;
    burst_left = 0;
    bytes_sent = 0;
    for (k = 0; k < PREG_COUNT; k++) pat_words[k] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Out of reset no pattern is in use.
    send_text("a", 1'b0);
    settle();

    write_reg(REG_PATTERN_ZERO, pack_text("AB"));
    write_reg(REG_PATTERN_ONE, pack_text("A?C"));
    write_reg(REG_PATTERN_TWO, pack_text("A*C"));
    write_reg(REG_PATTERN_THREE, pack_text("X*"));
    write_reg(REG_PATTERN_COUNT, 64'(PREG_COUNT));
    send_text("ab", 1'b1);
    send_text("axcx\n", 1'b0);
    offer_byte(8'h00, 1'b0);
    offer_byte(8'hFF, 1'b0);
    settle();

    // No folding, count past the pattern total, an empty pattern, a lone
    // star, and writes to indexes with no register behind them.
    write_reg(REG_FOLD_CASE, 64'd0);
    write_reg(REG_PATTERN_COUNT, 64'd7);
    write_reg(REG_PATTERN_TWO, 64'd0);
    write_reg(REG_PATTERN_THREE, pack_text("*"));
    write_reg(REG_SPARE_LO, {$urandom(), $urandom()});
    write_reg(REG_SPARE_HI, '1);
    send_text("abAB*", 1'b0);
    settle();

    // Rewriting a pattern under a half-done match leaves the position on the
    // pattern end; the full eight-byte pattern has no terminator at all.
    write_reg(REG_PATTERN_ZERO, pack_text("ABC"));
    write_reg(REG_PATTERN_ONE, pack_text("ABCDEFGH"));
    send_text("AB", 1'b0);
    settle();
    write_reg(REG_PATTERN_ZERO, pack_text("AB"));
    send_text("AABCDEFGH", 1'b0);
    settle();

    for (ph = 0; ph < RANDOM_SETTINGS; ph++) begin
      phase_no = ph + 1;
      for (k = 0; k < PREG_COUNT; k++) begin
        if (ph == 4) begin
          w = {$urandom(), $urandom()};
        end else begin
          r = $urandom_range(0, 9);
          n = (r == 0) ? 0 : (r == 9) ? 8 : $urandom_range(1, 4);
          w = '0;
          for (i = 0; i < n; i++) begin
            r = $urandom_range(0, 9);
            w[8*i +: 8] = (r < 6) ? filler_byte() : (r < 8) ? ANY_BYTE : STAR_BYTE;
          end
        end
        write_reg(CFG_INDEX_W'(REG_PATTERN_ZERO + k), w);
      end
      write_reg(REG_PATTERN_COUNT, 64'((ph == 0) ? PREG_COUNT : $urandom_range(1, 7)));
      write_reg(REG_FOLD_CASE, 64'(ph % 2));

      start = bytes_sent;
      while (bytes_sent - start < 62) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          // Spell out one stored pattern with its wildcards filled in.
          k = $urandom_range(0, PREG_COUNT - 1);
          for (i = 0; i < 8 && pat_words[k][8*i +: 8] != 8'h00; i++) begin
            b = pat_words[k][8*i +: 8];
            if (b == STAR_BYTE) begin
              repeat ($urandom_range(0, 2)) offer_byte(filler_byte(), 1'b0);
            end else begin
              if (b == ANY_BYTE) b = filler_byte();
              else if (ph % 2 == 1 && b >= "A" && b <= "Z" && $urandom_range(0, 1))
                b = b + CASE_OFFSET;
              offer_byte(b, 1'b0);
            end
          end
        end else if (r < 80) begin
          offer_byte(filler_byte() | ($urandom_range(0, 1) ? CASE_OFFSET : 8'h00), 1'b0);
        end else if (r < 87) begin
          offer_byte(NEWLINE_BYTE, 1'b0);
        end else if (r < 95) begin
          offer_byte(8'($urandom_range(0, 255)), 1'b0);
        end else begin
          offer_byte(filler_byte(), 1'b1);
        end
      end
      settle();
    end

    repeat (8) @(posedge clk);
    $display("Scanned %0d text bytes over directed wildcard and register cases", bytes_sent);
    $display("and %0d random pattern settings; %0d match words compared.",
             RANDOM_SETTINGS, matches_seen);
    if (outstanding != 0) $error("%0d predicted matches never came out", outstanding);
    if (errors == 0 && outstanding == 0) begin
      $display("** multi_wildcard_stream_matcher: PASSED **");
    end else begin
      $display("** multi_wildcard_stream_matcher: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mwsm_pkg.sv
rtl/multi_wildcard_stream_matcher.sv
verif/mwsm_checker.sv
verif/tb.sv
